### rtl/bb3_pkg.sv
// Package with shared types and constants for the 3x3 box blur.
`default_nettype none
package bb3_pkg;

    localparam int CFG_BITS            = 11;
    localparam int PIX_BITS            = 16;
    localparam int MAX_SIDE_DEF        = 1024;
    localparam int COMPONENT_BITS_DEF  = 16;
    localparam logic [CFG_BITS-1:0] SIDE_RESET = 11'd32;

    typedef struct packed {
        logic [PIX_BITS-1:0] red_in;
        logic [PIX_BITS-1:0] green_in;
        logic [PIX_BITS-1:0] blue_in;
        logic                fill;
    } pixel_in_t;

    typedef struct packed {
        logic [PIX_BITS-1:0] red_out;
        logic [PIX_BITS-1:0] green_out;
        logic [PIX_BITS-1:0] blue_out;
        logic                last_of_frame;
    } pixel_out_t;

    typedef struct packed {
        logic [2:0] row_ok;
        logic [2:0] col_ok;
    } clip_mask_t;

endpackage
`default_nettype wire

### rtl/box_blur_three_by_three.sv
// Top level of the streaming 3x3 box blur with border clipping.
//
//  Channel  Direction  Handshake                 Payload
//  cfg      in         cfg_write_en              cfg_write_data (image_side)
//  in       in         in_valid / in_ready       in_data  (bb3_pkg::pixel_in_t)
//  out      out        out_valid / out_ready     out_data (bb3_pkg::pixel_out_t)
//
// A request that yields no result goes through the line read, then window update and write-back.
// A request that yields a result goes through read, update, sum, reciprocal multiply and load, in that order.
// These steps come from the read-modify-write of the line memories and the sum/multiply steps.
// Reset clears the counters, window and output valid flag; line memories and output data are not cleared.
// A full output register that is not taken stalls the last step; input waits meanwhile.
`default_nettype none
module box_blur_three_by_three #(
    parameter int MAX_SIDE       = bb3_pkg::MAX_SIDE_DEF,
    parameter int COMPONENT_BITS = bb3_pkg::COMPONENT_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write_en,
    input  wire logic [bb3_pkg::CFG_BITS-1:0]  cfg_write_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire bb3_pkg::pixel_in_t            in_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output bb3_pkg::pixel_out_t                out_data
);

    localparam int PW  = 3 * COMPONENT_BITS;
    localparam int CW  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int RW  = $clog2(MAX_SIDE + 2);
    localparam int SDW = $clog2(MAX_SIDE + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_UPD  = 3'd1;
    localparam logic [2:0] S_SUM  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]                   state_reg, state_next;
    logic [bb3_pkg::CFG_BITS-1:0] side_reg;
    logic [SDW-1:0]               side_eff;
    logic [RW-1:0]                row_count_reg, row_count_next;
    logic [CW-1:0]                column_count_reg, column_count_next;
    logic [PW-1:0]                pix_reg;
    logic [8:0][PW-1:0]           window_reg, window_next;
    bb3_pkg::clip_mask_t          mask_reg, mask_next;
    logic                         last_reg, last_next;
    logic                         emit;
    logic [PW-1:0]                upper_rd, middle_rd;
    logic [RW-1:0]                oi;
    logic [CW-1:0]                oj;
    logic [CW:0]                  c_inc;
    logic [2:0][COMPONENT_BITS-1:0] quotient;
    logic                         out_valid_reg;
    bb3_pkg::pixel_out_t          out_data_reg;
    logic                         accept, load_out;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        if (side_reg == '0)
        begin
            side_eff = SDW'(1);
        end
        else if (32'(side_reg) > 32'(MAX_SIDE))
        begin
            side_eff = SDW'(MAX_SIDE);
        end
        else
        begin
            side_eff = SDW'(side_reg);
        end
    end

    bb3_ram #(.WIDTH(PW), .DEPTH(MAX_SIDE)) u_upper (
        .clk     (clk),
        .wr_en   (state_reg == S_UPD),
        .wr_addr (column_count_reg),
        .wr_data (middle_rd),
        .rd_en   (accept),
        .rd_addr (column_count_reg),
        .rd_data (upper_rd)
    );

    bb3_ram #(.WIDTH(PW), .DEPTH(MAX_SIDE)) u_middle (
        .clk     (clk),
        .wr_en   (state_reg == S_UPD),
        .wr_addr (column_count_reg),
        .wr_data (pix_reg),
        .rd_en   (accept),
        .rd_addr (column_count_reg),
        .rd_data (middle_rd)
    );

    bb3_mean #(.COMPONENT_BITS(COMPONENT_BITS)) u_mean (
        .clk      (clk),
        .sum_en   (state_reg == S_SUM),
        .mul_en   (state_reg == S_MUL),
        .window   (window_reg),
        .mask     (mask_reg),
        .quotient (quotient)
    );

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            window_next[k*3]     = window_reg[k*3+1];
            window_next[k*3+1]   = window_reg[k*3+2];
        end
        window_next[2] = upper_rd;
        window_next[5] = middle_rd;
        window_next[8] = pix_reg;

        emit = (row_count_reg >= RW'(2)) ||
               (row_count_reg == RW'(1) && column_count_reg != '0);
        if (column_count_reg != '0)
        begin
            oi = row_count_reg - RW'(1);
            oj = column_count_reg - CW'(1);
        end
        else
        begin
            oi = row_count_reg - RW'(2);
            oj = CW'(side_eff - SDW'(1));
        end
        mask_next.row_ok[0] = (oi != '0);
        mask_next.row_ok[1] = 1'b1;
        mask_next.row_ok[2] = (32'(oi) + 32'd1 < 32'(side_eff));
        mask_next.col_ok[0] = (oj != '0);
        mask_next.col_ok[1] = 1'b1;
        mask_next.col_ok[2] = (32'(oj) + 32'd1 < 32'(side_eff));
        last_next = (32'(oi) + 32'd1 == 32'(side_eff)) && (32'(oj) + 32'd1 == 32'(side_eff));

        c_inc = {1'b0, column_count_reg} + (CW+1)'(1);
        if (32'(row_count_reg) >= 32'(side_eff) + 32'd1)
        begin
            row_count_next    = '0;
            column_count_next = '0;
        end
        else if (32'(c_inc) >= 32'(side_eff))
        begin
            row_count_next    = row_count_reg + RW'(1);
            column_count_next = '0;
        end
        else
        begin
            row_count_next    = row_count_reg;
            column_count_next = c_inc[CW-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (accept) state_next = S_UPD;
            S_UPD:  state_next = emit ? S_SUM : S_IDLE;
            S_SUM:  state_next = S_MUL;
            S_MUL:  state_next = S_DONE;
            S_DONE: if (load_out) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            side_reg         <= bb3_pkg::SIDE_RESET;
            row_count_reg    <= '0;
            column_count_reg <= '0;
            window_reg       <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write_en)
            begin
                side_reg         <= cfg_write_data;
                row_count_reg    <= '0;
                column_count_reg <= '0;
            end
            else if (state_reg == S_UPD)
            begin
                row_count_reg    <= row_count_next;
                column_count_reg <= column_count_next;
            end
            if (state_reg == S_UPD)
            begin
                window_reg <= window_next;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_reg <= in_data.fill ? '0 :
                {in_data.blue_in[COMPONENT_BITS-1:0], in_data.green_in[COMPONENT_BITS-1:0],
                 in_data.red_in[COMPONENT_BITS-1:0]};
        end
        if (state_reg == S_UPD)
        begin
            mask_reg <= mask_next;
            last_reg <= last_next;
        end
        if (load_out)
        begin
            out_data_reg.red_out       <= bb3_pkg::PIX_BITS'(quotient[0]);
            out_data_reg.green_out     <= bb3_pkg::PIX_BITS'(quotient[1]);
            out_data_reg.blue_out      <= bb3_pkg::PIX_BITS'(quotient[2]);
            out_data_reg.last_of_frame <= last_reg;
        end
    end

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(column_count_reg) < 32'(side_eff))
        else $error("column counter beyond image side");

    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !out_valid_reg) |=> out_valid_reg)
        else $error("finished result not loaded");

    a_rose_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result appeared outside the final step");

endmodule
`default_nettype wire

### rtl/bb3_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
`default_nettype none
module bb3_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

### rtl/bb3_mean.sv
// Masked 3x3 sum and division by the neighbor count through a reciprocal multiply.
`default_nettype none
module bb3_mean #(
    parameter int COMPONENT_BITS = bb3_pkg::COMPONENT_BITS_DEF,
    localparam int PW = 3 * COMPONENT_BITS
) (
    input  wire logic                      clk,
    input  wire logic                      sum_en,
    input  wire logic                      mul_en,
    input  wire logic [9*PW-1:0]           window,
    input  wire bb3_pkg::clip_mask_t       mask,
    output logic [2:0][COMPONENT_BITS-1:0] quotient
);

    localparam int SUMW = COMPONENT_BITS + 4;
    localparam int SH   = SUMW + 4;
    localparam int RECW = SH + 1;
    localparam int PRODW = SUMW + RECW;
    localparam logic [RECW-1:0] RECIP_1 = RECW'(64'd1 << SH);
    localparam logic [RECW-1:0] RECIP_2 = RECW'(((64'd1 << SH) + 64'd1) / 64'd2);
    localparam logic [RECW-1:0] RECIP_3 = RECW'(((64'd1 << SH) + 64'd2) / 64'd3);
    localparam logic [RECW-1:0] RECIP_4 = RECW'(((64'd1 << SH) + 64'd3) / 64'd4);
    localparam logic [RECW-1:0] RECIP_6 = RECW'(((64'd1 << SH) + 64'd5) / 64'd6);
    localparam logic [RECW-1:0] RECIP_9 = RECW'(((64'd1 << SH) + 64'd8) / 64'd9);

    logic [2:0][SUMW-1:0]  sum_reg, sum_next;
    logic [RECW-1:0]       recip_reg, recip_next;
    logic [2:0][PRODW-1:0] prod_reg;
    logic [1:0]            rn, cn;
    logic [3:0]            cnt;

    always_comb
    begin
        sum_next = '0;
        for (int wr = 0; wr < 3; wr++)
        begin
            for (int wc = 0; wc < 3; wc++)
            begin
                if (mask.row_ok[wr] && mask.col_ok[wc])
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        sum_next[k] = sum_next[k] + SUMW'(window[(wr*3+wc)*PW
                            + k*COMPONENT_BITS +: COMPONENT_BITS]);
                    end
                end
            end
        end
        rn  = 2'd1 + 2'(mask.row_ok[0]) + 2'(mask.row_ok[2]);
        cn  = 2'd1 + 2'(mask.col_ok[0]) + 2'(mask.col_ok[2]);
        cnt = 4'(rn) * 4'(cn);
        case (cnt)
            4'd2:    recip_next = RECIP_2;
            4'd3:    recip_next = RECIP_3;
            4'd4:    recip_next = RECIP_4;
            4'd6:    recip_next = RECIP_6;
            4'd9:    recip_next = RECIP_9;
            default: recip_next = RECIP_1;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (sum_en)
        begin
            sum_reg   <= sum_next;
            recip_reg <= recip_next;
        end
        if (mul_en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod_reg[k] <= PRODW'(sum_reg[k]) * PRODW'(recip_reg);
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            quotient[k] = prod_reg[k][SH +: COMPONENT_BITS];
        end
    end

endmodule
`default_nettype wire

### tb/sv/tb_top.sv
// Testbench for the streaming 3x3 box blur: directed and random frames checked against a local predictor.
`timescale 1ns / 100ps
module tb_top;

    localparam int LINE_DEPTH = 1024;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_write_en;
    logic [bb3_pkg::CFG_BITS-1:0] cfg_write_data;
    logic                         in_valid;
    logic                         in_ready;
    bb3_pkg::pixel_in_t           in_data;
    logic                         out_valid;
    logic                         out_ready;
    bb3_pkg::pixel_out_t          out_data;

    box_blur_three_by_three DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_data       (out_data)
    );

    logic [47:0]                  upper_row [LINE_DEPTH];
    logic [47:0]                  middle_row [LINE_DEPTH];
    logic [47:0]                  blur_window [9];
    logic [10:0]                  pos_row;
    logic [10:0]                  pos_col;
    logic [bb3_pkg::CFG_BITS-1:0] side_reg;
    bb3_pkg::pixel_out_t          blurred_pixels [$];
    int                           fail_count;
    int                           sent_count;
    int                           seen_count;
    bit                           quiet;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("simulation failed");
        $finish;
    end

    function automatic int clamp_side();
        int s;
        s = side_reg;
        if (s < 1) s = 1;
        if (s > LINE_DEPTH) s = LINE_DEPTH;
        return s;
    endfunction

    function automatic void blur_predict(bb3_pkg::pixel_in_t p);
        int                  side;
        int                  r;
        int                  c;
        int                  oi;
        int                  oj;
        int                  cnt;
        int                  sums [3];
        logic [47:0]         px;
        logic [47:0]         col_vec [3];
        bit                  row_ok [3];
        bit                  col_ok [3];
        bb3_pkg::pixel_out_t res;
        side = clamp_side();
        r = pos_row;
        c = pos_col;
        px = p.fill ? 48'd0 : {p.blue_in, p.green_in, p.red_in};
        col_vec[0] = upper_row[c];
        col_vec[1] = middle_row[c];
        col_vec[2] = px;
        upper_row[c] = middle_row[c];
        middle_row[c] = px;
        for (int k = 0; k < 3; k++)
        begin
            blur_window[k*3] = blur_window[k*3+1];
            blur_window[k*3+1] = blur_window[k*3+2];
            blur_window[k*3+2] = col_vec[k];
        end
        if (r >= 2 || (r == 1 && c >= 1))
        begin
            if (c > 0)
            begin
                oi = r - 1;
                oj = c - 1;
            end
            else
            begin
                oi = r - 2;
                oj = side - 1;
            end
            row_ok[0] = oi > 0;
            row_ok[1] = 1;
            row_ok[2] = oi + 1 < side;
            col_ok[0] = oj > 0;
            col_ok[1] = 1;
            col_ok[2] = oj + 1 < side;
            cnt = 0;
            sums = '{0, 0, 0};
            for (int wr = 0; wr < 3; wr++)
                for (int wc = 0; wc < 3; wc++)
                    if (row_ok[wr] && col_ok[wc])
                    begin
                        for (int q = 0; q < 3; q++)
                            sums[q] += blur_window[wr*3+wc][q*16 +: 16];
                        cnt++;
                    end
            res.red_out = 16'(sums[0] / cnt);
            res.green_out = 16'(sums[1] / cnt);
            res.blue_out = 16'(sums[2] / cnt);
            res.last_of_frame = (oi == side - 1 && oj == side - 1);
            blurred_pixels.push_back(res);
        end
        if (r >= side + 1)
        begin
            pos_row = 0;
            pos_col = 0;
        end
        else
        begin
            c++;
            if (c >= side)
            begin
                c = 0;
                r++;
            end
            pos_row = 11'(r);
            pos_col = 11'(c);
        end
    endfunction

    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!quiet && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            seen_count++;
            if (blurred_pixels.size() == 0)
            begin
                $error("unexpected result %p", out_data);
                fail_count++;
            end
            else
            begin
                bb3_pkg::pixel_out_t exp_px;
                exp_px = blurred_pixels.pop_front();
                if (out_data.red_out !== exp_px.red_out)
                begin
                    $error("red_out: expected %0d, actual %0d", exp_px.red_out, out_data.red_out);
                    fail_count++;
                end
                if (out_data.green_out !== exp_px.green_out)
                begin
                    $error("green_out: expected %0d, actual %0d",
                           exp_px.green_out, out_data.green_out);
                    fail_count++;
                end
                if (out_data.blue_out !== exp_px.blue_out)
                begin
                    $error("blue_out: expected %0d, actual %0d",
                           exp_px.blue_out, out_data.blue_out);
                    fail_count++;
                end
                if (out_data.last_of_frame !== exp_px.last_of_frame)
                begin
                    $error("last_of_frame: expected %0d, actual %0d",
                           exp_px.last_of_frame, out_data.last_of_frame);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_pixel(bb3_pkg::pixel_in_t p);
        in_valid <= 1'b1;
        in_data <= p;
        do @(posedge clk); while (!in_ready);
        blur_predict(p);
        sent_count++;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (blurred_pixels.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_side(logic [bb3_pkg::CFG_BITS-1:0] v);
        drain_results();
        cfg_write_en <= 1'b1;
        cfg_write_data <= v;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        side_reg = v;
        pos_row = 0;
        pos_col = 0;
    endtask

    function automatic bb3_pkg::pixel_in_t random_pixel(bit fill, int mode);
        bb3_pkg::pixel_in_t p;
        p.red_in = 16'($urandom);
        p.green_in = 16'($urandom);
        p.blue_in = 16'($urandom);
        if (mode == 1) p = {16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0};
        if (mode == 2) p = '0;
        p.fill = fill;
        return p;
    endfunction

    // Sends count items of a frame, at most side*side+side+1; noise flips the fill bit on some items.
    task automatic send_frame(int side, int count, bit noise, int mode);
        int total;
        bit fill;
        total = side * side + side + 1;
        for (int k = 0; k < count && k < total; k++)
        begin
            fill = (k >= side * side);
            if (noise && $urandom_range(0, 9) == 0) fill = ~fill;
            send_pixel(random_pixel(fill, mode));
        end
    endtask

    task automatic test_directed();
        write_side(11'd1);
        send_frame(1, 3, 0, 1);
        write_side(11'd0);
        send_frame(1, 3, 0, 0);
        write_side(11'd2);
        send_frame(2, 7, 0, 1);
        write_side(11'd3);
        send_frame(3, 13, 1, 2);
    endtask

    task automatic test_default_side();
        side_reg = bb3_pkg::SIDE_RESET;
        send_frame(32, 40, 0, 0);
    endtask

    task automatic test_random_frames();
        int s;
        while (sent_count < 800)
        begin
            s = $urandom_range(1, 9);
            write_side(11'(s));
            if ($urandom_range(0, 7) == 0)
                send_frame(s, $urandom_range(1, s * s), 1, 0);
            else
                send_frame(s, s * s + s + 1, $urandom_range(0, 3) == 0, 0);
        end
    endtask

    task automatic test_back_to_back();
        quiet = 1;
        write_side(11'd5);
        for (int f = 0; f < 4; f++)
            send_frame(5, 31, 0, 0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_write_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        fail_count = 0;
        sent_count = 0;
        seen_count = 0;
        quiet = 0;
        side_reg = bb3_pkg::SIDE_RESET;
        pos_row = 0;
        pos_col = 0;
        for (int i = 0; i < LINE_DEPTH; i++)
        begin
            upper_row[i] = '0;
            middle_row[i] = '0;
        end
        for (int i = 0; i < 9; i++) blur_window[i] = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_side();
        test_directed();
        test_random_frames();
        test_back_to_back();
        drain_results();
        repeat (20) @(posedge clk);
        $display("Sent %0d pixels over sides 0 to 9 and 32; checked %0d blurred pixels.",
                 sent_count, seen_count);
        if (fail_count == 0 && blurred_pixels.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
